// ===== sv/spsu_pkg.sv =====
// ----------------------------------------------------------------------------
// spsu_pkg
// Shared types, widths and constants of the swerve module pd steering unit.
// ----------------------------------------------------------------------------
`default_nettype none
package spsu_pkg;

	// field widths
	localparam int LEN_W      = 12;
	localparam int GAIN_W     = 32;
	localparam int CPT_W      = 8;
	localparam int CMD_W      = 16;
	localparam int PIV_W      = 16;
	localparam int SPD_W      = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// internal widths
	localparam int K_W      = 17;  // chassis ratio, q1.16, up to 1.0
	localparam int COMP_W   = 18;  // mixed component
	localparam int SQ_W     = 34;  // square root operand
	localparam int ROOT_W   = 17;
	localparam int KNUM_W   = 56;  // ratio dividend width
	localparam int DIVR_W   = 25;  // divisor width
	localparam int XW       = 20;  // cordic x / y
	localparam int ZW       = 26;  // cordic angle, q.16 degrees
	localparam int AT_W     = 22;
	localparam int IDX_W    = 5;
	localparam int ANG_W    = 17;  // setpoint, q.7 degrees
	localparam int QUOT_W   = 33;
	localparam int CUR_W    = 49;  // current angle, q.7 degrees
	localparam int ERR_W    = 48;
	localparam int DER_W    = 49;
	localparam int OP_W     = 50;
	localparam int HALF_W   = 25;
	localparam int MB_W     = 26;
	localparam int MP_W     = 58;
	localparam int PROD_W   = 84;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CPT    = 3'd4;

	// register reset values
	localparam logic [LEN_W-1:0]  LENGTH_RST = 12'd600;
	localparam logic [LEN_W-1:0]  WIDTH_RST  = 12'd600;
	localparam logic [CPT_W-1:0]  CPT_RST    = 8'd5;

	// quotient clamp keeps the angle below 2^48 in q.7
	localparam logic [QUOT_W-1:0] QUOT_MAX   = 33'd6108397932;
	// 360 degrees times 2^7
	localparam logic [15:0]       DEG_SCALE  = 16'd46080;
	// 90 degrees in q.16
	localparam logic signed [ZW-1:0] Z_QUARTER = 26'sd5898240;

	// atan(2^-i) in degrees, q.16
	function automatic logic [AT_W-1:0] atan_deg(input logic [IDX_W-1:0] i);
		logic [AT_W-1:0] v;
		begin
			case (i)
				5'd0:  v = 22'd2949120;
				5'd1:  v = 22'd1740967;
				5'd2:  v = 22'd919879;
				5'd3:  v = 22'd466945;
				5'd4:  v = 22'd234379;
				5'd5:  v = 22'd117304;
				5'd6:  v = 22'd58666;
				5'd7:  v = 22'd29335;
				5'd8:  v = 22'd14668;
				5'd9:  v = 22'd7334;
				5'd10: v = 22'd3667;
				5'd11: v = 22'd1833;
				5'd12: v = 22'd917;
				5'd13: v = 22'd458;
				5'd14: v = 22'd229;
				5'd15: v = 22'd115;
				5'd16: v = 22'd57;
				5'd17: v = 22'd29;
				5'd18: v = 22'd14;
				5'd19: v = 22'd7;
				5'd20: v = 22'd4;
				5'd21: v = 22'd2;
				5'd22: v = 22'd1;
				default: v = 22'd0;
			endcase
			return v;
		end
	endfunction

	typedef struct packed {
		logic       load;
		logic       k_div;
		logic       k_sqrt;
		logic       k_store;
		logic       comp;
		logic       sq1;
		logic       sq2;
		logic       go;
		logic       err;
		logic       mul;
		logic       acc;
		logic       acc_clr;
		logic       store;
		logic       publish;
		logic [1:0] idx;
		logic [1:0] mul_sel;
	} spsu_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
		logic cordic_busy;
	} spsu_sts_t;

endpackage
`default_nettype wire

// ===== sv/spsu_div.sv =====
// ----------------------------------------------------------------------------
// spsu_div
// Restoring divider, one quotient bit per cycle, dividend left aligned.
// ----------------------------------------------------------------------------
`default_nettype none
module spsu_div #(
	parameter int DIV_W  = 56,
	parameter int STEP_W = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [DIV_W-1:0]              dividend,
	input  wire logic [spsu_pkg::DIVR_W-1:0]   divisor,
	input  wire logic [STEP_W-1:0]             steps,
	output logic                               busy,
	output logic [DIV_W-1:0]                   quot
);

	logic [spsu_pkg::DIVR_W-1:0] rem_q;
	logic [DIV_W-1:0]            dq_q;
	logic [STEP_W-1:0]           cnt_q;
	logic [spsu_pkg::DIVR_W-1:0] dvs_q;
	logic                        busy_q;
	logic [spsu_pkg::DIVR_W:0]   trial;
	logic                        fit;

	assign trial = {rem_q, dq_q[DIV_W-1]};
	assign fit   = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q) begin
			busy_q <= (cnt_q != STEP_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			cnt_q <= steps;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fit ? spsu_pkg::DIVR_W'(trial - {1'b0, dvs_q})
				: trial[spsu_pkg::DIVR_W-1:0];
			dq_q  <= {dq_q[DIV_W-2:0], fit};
			cnt_q <= cnt_q - STEP_W'(1);
		end
	end

	assign busy = busy_q;
	assign quot = dq_q;

endmodule
`default_nettype wire

// ===== sv/spsu_sqrt.sv =====
// ----------------------------------------------------------------------------
// spsu_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module spsu_sqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [spsu_pkg::SQ_W-1:0]     operand,
	output logic                               busy,
	output logic [spsu_pkg::ROOT_W-1:0]        root
);

	localparam int W = spsu_pkg::SQ_W;

	logic [W-1:0] n_q, r_q, b_q;
	logic         busy_q;
	logic [W:0]   t;
	logic         ge;

	assign t  = {1'b0, r_q} + {1'b0, b_q};
	assign ge = {1'b0, n_q} >= t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q) begin
			busy_q <= |b_q[W-1:2];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= operand;
			r_q <= '0;
			b_q <= W'(1) << (W - 2);
		end else if (busy_q) begin
			if (ge) begin
				n_q <= n_q - t[W-1:0];
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = r_q[spsu_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== sv/spsu_cordic.sv =====
// ----------------------------------------------------------------------------
// spsu_cordic
// Vectoring cordic, atan2 in q.7 degrees, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module spsu_cordic #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic signed [spsu_pkg::COMP_W-1:0]   y_in,
	input  wire logic signed [spsu_pkg::COMP_W-1:0]   x_in,
	output logic                                      busy,
	output logic signed [spsu_pkg::ANG_W-1:0]         angle
);

	localparam int XW = spsu_pkg::XW;
	localparam int ZW = spsu_pkg::ZW;

	logic signed [XW-1:0]            x_q, y_q, xe, ye, dx, dy;
	logic signed [ZW-1:0]            z_q, at, zr;
	logic [spsu_pkg::IDX_W-1:0]      i_q;
	logic                            zero_q, busy_q;

	assign xe = XW'(x_in);
	assign ye = XW'(y_in);
	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = $signed(ZW'(spsu_pkg::atan_deg(i_q)));
	assign zr = (z_q + ZW'(256)) >>> 9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q) begin
			busy_q <= (i_q != spsu_pkg::IDX_W'(CORDIC_ITERATIONS - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (x_in == '0) && (y_in == '0);
			i_q    <= '0;
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_q <= ye;
					y_q <= -xe;
					z_q <= spsu_pkg::Z_QUARTER;
				end else begin
					x_q <= -ye;
					y_q <= xe;
					z_q <= -spsu_pkg::Z_QUARTER;
				end
			end else begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end
			i_q <= i_q + spsu_pkg::IDX_W'(1);
		end
	end

	assign busy  = busy_q;
	assign angle = zero_q ? '0 : zr[spsu_pkg::ANG_W-1:0];

endmodule
`default_nettype wire

// ===== sv/spsu_dpath.sv =====
// ----------------------------------------------------------------------------
// spsu_dpath
// Datapath: chassis ratios, command mixing, per wheel speed, setpoint,
// current angle, pd error and drive.
// ----------------------------------------------------------------------------
`default_nettype none
module spsu_dpath #(
	parameter int COUNT_WIDTH       = 32,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire spsu_pkg::spsu_cmd_t                   cmd,
	output spsu_pkg::spsu_sts_t                        sts,
	input  wire logic [spsu_pkg::LEN_W-1:0]            len,
	input  wire logic [spsu_pkg::LEN_W-1:0]            wid,
	input  wire logic signed [spsu_pkg::GAIN_W-1:0]    kp,
	input  wire logic signed [spsu_pkg::GAIN_W-1:0]    kd,
	input  wire logic [spsu_pkg::CPT_W-1:0]            cpt,
	input  wire logic signed [spsu_pkg::CMD_W-1:0]     strafe_x,
	input  wire logic signed [spsu_pkg::CMD_W-1:0]     forward_y,
	input  wire logic signed [spsu_pkg::CMD_W-1:0]     turn_rate,
	input  wire logic signed [COUNT_WIDTH-1:0]         count_front_right,
	input  wire logic signed [COUNT_WIDTH-1:0]         count_front_left,
	input  wire logic signed [COUNT_WIDTH-1:0]         count_back_right,
	input  wire logic signed [COUNT_WIDTH-1:0]         count_back_left,
	output logic [3:0][spsu_pkg::PIV_W-1:0]            pivot_res,
	output logic [3:0][spsu_pkg::SPD_W-1:0]            speed_res
);

	localparam int CW     = COUNT_WIDTH;
	localparam int KN     = spsu_pkg::KNUM_W;
	localparam int DIV_W  = (CW > KN) ? CW : KN;
	localparam int STEP_W = $clog2(DIV_W + 1);

	// captured item
	logic signed [spsu_pkg::CMD_W-1:0] x_q, y_q, t_q;
	logic [3:0][CW-1:0]                cnt_q;

	// ratios and components
	logic [spsu_pkg::K_W-1:0]             kl_q, kw_q;
	logic signed [spsu_pkg::COMP_W-1:0]   a_q, b_q, c_q, d_q;

	// per wheel
	logic [spsu_pkg::SQ_W-1:0]            sqp_q, sumsq_q;
	logic                                 neg_q;
	logic signed [spsu_pkg::ERR_W-1:0]    err_q;
	logic signed [spsu_pkg::DER_W-1:0]    der_q;
	logic signed [spsu_pkg::ERR_W-1:0]    prev_q [4];
	logic signed [spsu_pkg::PROD_W-1:0]   prod_q, acc_q;

	// ratio division
	logic [2*spsu_pkg::LEN_W-1:0] l2, w2, knum;
	logic [spsu_pkg::DIVR_W-1:0]  ksum;
	assign l2   = len * len;
	assign w2   = wid * wid;
	assign ksum = spsu_pkg::DIVR_W'(l2) + spsu_pkg::DIVR_W'(w2);
	assign knum = cmd.idx[0] ? w2 : l2;

	// count magnitude
	logic [CW-1:0] cnt_sel, cnt_mag;
	logic          cnt_neg;
	assign cnt_sel = cnt_q[cmd.idx];
	assign cnt_neg = cnt_sel[CW-1];
	assign cnt_mag = cnt_neg ? (~cnt_sel + CW'(1)) : cnt_sel;

	// divider operands
	logic [DIV_W-1:0]            div_dvd, div_quot;
	logic [spsu_pkg::DIVR_W-1:0] div_dvs;
	logic [STEP_W-1:0]           div_steps;
	logic                        div_busy;

	always_comb begin
		if (cmd.go) begin
			div_dvd   = DIV_W'(cnt_mag) << (DIV_W - CW);
			div_dvs   = (cpt == '0) ? spsu_pkg::DIVR_W'(1) : spsu_pkg::DIVR_W'(cpt);
			div_steps = STEP_W'(CW);
		end else begin
			div_dvd   = DIV_W'({knum, 32'd0}) << (DIV_W - KN);
			div_dvs   = ksum;
			div_steps = STEP_W'(KN);
		end
	end

	spsu_div #(
		.DIV_W (DIV_W),
		.STEP_W(STEP_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.k_div | cmd.go),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.steps   (div_steps),
		.busy    (div_busy),
		.quot    (div_quot)
	);

	// square root, shared by ratios and speeds
	logic [spsu_pkg::SQ_W-1:0]   sq_in;
	logic [spsu_pkg::ROOT_W-1:0] root;
	logic                        sqrt_busy;
	assign sq_in = cmd.k_sqrt ? div_quot[spsu_pkg::SQ_W-1:0] : sumsq_q;

	spsu_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.k_sqrt | cmd.go),
		.operand(sq_in),
		.busy   (sqrt_busy),
		.root   (root)
	);

	// wheel pair: front right (b,d), front left (b,c), back right (a,d), back left (a,c)
	logic signed [spsu_pkg::COMP_W-1:0] first, second;
	assign first  = cmd.idx[1] ? a_q : b_q;
	assign second = cmd.idx[0] ? c_q : d_q;

	logic signed [spsu_pkg::ANG_W-1:0] setp;
	logic                              cordic_busy;

	spsu_cordic #(
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.go),
		.y_in  (first),
		.x_in  (second),
		.busy  (cordic_busy),
		.angle (setp)
	);

	assign sts.div_busy    = div_busy;
	assign sts.sqrt_busy   = sqrt_busy;
	assign sts.cordic_busy = cordic_busy;

	// mixing
	logic signed [16:0] mix;
	logic signed [17:0] kext;
	logic signed [34:0] mprod;
	always_comb begin
		case (cmd.idx)
			2'd0:    mix = $signed({x_q[15], x_q}) - $signed({t_q[15], t_q});
			2'd1:    mix = $signed({x_q[15], x_q}) + $signed({t_q[15], t_q});
			2'd2:    mix = $signed({y_q[15], y_q}) - $signed({t_q[15], t_q});
			default: mix = $signed({y_q[15], y_q}) + $signed({t_q[15], t_q});
		endcase
	end
	assign kext  = $signed({1'b0, cmd.idx[1] ? kw_q : kl_q});
	assign mprod = mix * kext;

	// squares
	logic signed [35:0] sq_p, sq_q;
	assign sq_p = first * first;
	assign sq_q = second * second;

	// current angle and error
	logic [DIV_W-1:0]                  q_full;
	logic [spsu_pkg::QUOT_W-1:0]       q_cl;
	logic [48:0]                       c_mag;
	logic signed [spsu_pkg::CUR_W-1:0] cur;
	logic signed [spsu_pkg::OP_W-1:0]  err_raw;
	logic signed [spsu_pkg::ERR_W-1:0] err_n;
	logic signed [spsu_pkg::DER_W-1:0] der_n;

	assign q_full = DIV_W'(div_quot[CW-1:0]);
	assign q_cl   = (q_full > DIV_W'(spsu_pkg::QUOT_MAX)) ? spsu_pkg::QUOT_MAX
		: q_full[spsu_pkg::QUOT_W-1:0];
	assign c_mag  = q_cl * spsu_pkg::DEG_SCALE;
	assign cur    = neg_q ? $signed({1'b0, c_mag[47:0]}) : -$signed({1'b0, c_mag[47:0]});
	assign err_raw = spsu_pkg::OP_W'(cur) - spsu_pkg::OP_W'(setp);

	always_comb begin
		if ((err_raw[49:47] == 3'b000) || (err_raw[49:47] == 3'b111)) begin
			err_n = err_raw[spsu_pkg::ERR_W-1:0];
		end else if (err_raw[49]) begin
			err_n = {1'b1, {(spsu_pkg::ERR_W-1){1'b0}}};
		end else begin
			err_n = {1'b0, {(spsu_pkg::ERR_W-1){1'b1}}};
		end
	end
	assign der_n = spsu_pkg::DER_W'(err_n) - spsu_pkg::DER_W'(prev_q[cmd.idx]);

	// pd multiply, operand cut in two halves
	logic signed [spsu_pkg::OP_W-1:0]   op;
	logic signed [spsu_pkg::GAIN_W-1:0] g;
	logic signed [spsu_pkg::MB_W-1:0]   mb;
	logic signed [spsu_pkg::MP_W-1:0]   mp;
	logic signed [spsu_pkg::PROD_W-1:0] mp_ext;
	assign op = cmd.mul_sel[1] ? spsu_pkg::OP_W'(der_q) : spsu_pkg::OP_W'(err_q);
	assign g  = cmd.mul_sel[1] ? kd : kp;
	assign mb = cmd.mul_sel[0] ? spsu_pkg::MB_W'($signed(op[49:25]))
		: $signed({1'b0, op[24:0]});
	assign mp     = g * mb;
	assign mp_ext = spsu_pkg::PROD_W'(mp);

	// drive saturation
	logic signed [75:0]                 shr;
	logic signed [spsu_pkg::PIV_W-1:0]  drv;
	assign shr = acc_q[83:8];
	always_comb begin
		if (shr > 76'sd32767) begin
			drv = 16'sh7FFF;
		end else if (shr < -76'sd32768) begin
			drv = 16'sh8000;
		end else begin
			drv = shr[15:0];
		end
	end

	// previous errors are state and reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				prev_q[i] <= '0;
			end
		end else if (cmd.err) begin
			prev_q[cmd.idx] <= err_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= strafe_x;
			y_q      <= forward_y;
			t_q      <= turn_rate;
			cnt_q[0] <= count_front_right;
			cnt_q[1] <= count_front_left;
			cnt_q[2] <= count_back_right;
			cnt_q[3] <= count_back_left;
		end
		if (cmd.k_store) begin
			if (cmd.idx[0]) begin
				kw_q <= (ksum == '0) ? '0 : root;
			end else begin
				kl_q <= (ksum == '0) ? '0 : root;
			end
		end
		if (cmd.comp) begin
			case (cmd.idx)
				2'd0:    a_q <= mprod[33:16];
				2'd1:    b_q <= mprod[33:16];
				2'd2:    c_q <= mprod[33:16];
				default: d_q <= mprod[33:16];
			endcase
		end
		if (cmd.sq1) begin
			sqp_q <= sq_p[spsu_pkg::SQ_W-1:0];
		end
		if (cmd.sq2) begin
			sumsq_q <= sqp_q + sq_q[spsu_pkg::SQ_W-1:0];
		end
		if (cmd.go) begin
			neg_q <= cnt_neg;
		end
		if (cmd.err) begin
			err_q <= err_n;
			der_q <= der_n;
		end
		if (cmd.mul) begin
			prod_q <= cmd.mul_sel[0] ? (mp_ext <<< 25) : mp_ext;
		end
		if (cmd.acc) begin
			acc_q <= (cmd.acc_clr ? '0 : acc_q) + prod_q;
		end
		if (cmd.store) begin
			pivot_res[cmd.idx] <= drv;
			speed_res[cmd.idx] <= root;
		end
	end

endmodule
`default_nettype wire

// ===== sv/spsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// spsu_ctrl
// Sequencer: ratio refresh when the ratios are dirty, mixing, then four wheel passes and hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module spsu_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 k_dirty,
	input  wire logic                 out_hold,
	input  wire spsu_pkg::spsu_sts_t  sts,
	output spsu_pkg::spsu_cmd_t       cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_KDIV   = 4'd1;
	localparam logic [3:0] S_KDWAIT = 4'd2;
	localparam logic [3:0] S_KSQRT  = 4'd3;
	localparam logic [3:0] S_KSWAIT = 4'd4;
	localparam logic [3:0] S_COMP   = 4'd5;
	localparam logic [3:0] S_SQ1    = 4'd6;
	localparam logic [3:0] S_SQ2    = 4'd7;
	localparam logic [3:0] S_GO     = 4'd8;
	localparam logic [3:0] S_WAIT   = 4'd9;
	localparam logic [3:0] S_ERR    = 4'd10;
	localparam logic [3:0] S_MUL    = 4'd11;
	localparam logic [3:0] S_STORE  = 4'd12;
	localparam logic [3:0] S_DONE   = 4'd13;

	logic [3:0] state_q, state_n;
	logic [1:0] idx_q, idx_n;
	logic [2:0] cnt_q, cnt_n;
	logic       units_busy;

	assign units_busy = sts.div_busy | sts.sqrt_busy | sts.cordic_busy;

	always_comb begin
		state_n  = state_q;
		idx_n    = idx_q;
		cnt_n    = cnt_q;
		cmd      = '0;
		cmd.idx  = idx_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					idx_n    = 2'd0;
					state_n  = k_dirty ? S_KDIV : S_COMP;
				end
			end
			S_KDIV: begin
				cmd.k_div = 1'b1;
				state_n   = S_KDWAIT;
			end
			S_KDWAIT: begin
				if (!sts.div_busy) begin
					state_n = S_KSQRT;
				end
			end
			S_KSQRT: begin
				cmd.k_sqrt = 1'b1;
				state_n    = S_KSWAIT;
			end
			S_KSWAIT: begin
				if (!sts.sqrt_busy) begin
					cmd.k_store = 1'b1;
					if (idx_q == 2'd1) begin
						idx_n   = 2'd0;
						state_n = S_COMP;
					end else begin
						idx_n   = 2'd1;
						state_n = S_KDIV;
					end
				end
			end
			S_COMP: begin
				cmd.comp = 1'b1;
				idx_n    = idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					state_n = S_SQ1;
				end
			end
			S_SQ1: begin
				cmd.sq1 = 1'b1;
				state_n = S_SQ2;
			end
			S_SQ2: begin
				cmd.sq2 = 1'b1;
				state_n = S_GO;
			end
			S_GO: begin
				cmd.go  = 1'b1;
				state_n = S_WAIT;
			end
			S_WAIT: begin
				if (!units_busy) begin
					state_n = S_ERR;
				end
			end
			S_ERR: begin
				cmd.err = 1'b1;
				cnt_n   = 3'd0;
				state_n = S_MUL;
			end
			S_MUL: begin
				cmd.mul     = (cnt_q != 3'd4);
				cmd.mul_sel = cnt_q[1:0];
				cmd.acc     = (cnt_q != 3'd0);
				cmd.acc_clr = (cnt_q == 3'd1);
				cnt_n       = cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					state_n = S_STORE;
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				idx_n     = idx_q + 2'd1;
				state_n   = (idx_q == 2'd3) ? S_DONE : S_SQ1;
			end
			S_DONE: begin
				if (!out_hold) begin
					cmd.publish = 1'b1;
					state_n     = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= 2'd0;
			cnt_q   <= 3'd0;
		end else begin
			state_q <= state_n;
			idx_q   <= idx_n;
			cnt_q   <= cnt_n;
		end
	end

endmodule
`default_nettype wire

// ===== sv/swerve_module_pd_steering_unit.sv =====
// ----------------------------------------------------------------------------
// swerve_module_pd_steering_unit
// Swerve drive kinematics with per-wheel pd steering, one word per tick.
// ----------------------------------------------------------------------------
// each wheel waits on the slowest of count divider, root and cordic
// a change of chassis length or width makes the next word redo the ratio
//   divides and roots first
// a new word is taken only once the last one is published, but while that
//   result still waits at the output register
// reset: registers take their reset values, previous errors clear to zero
`default_nettype none
module swerve_module_pd_steering_unit #(
	parameter int COUNT_WIDTH       = 32,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	// configuration write channel
	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire logic [spsu_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [spsu_pkg::CFG_DATA_W-1:0]         cfg_data,
	// input channel
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	input  wire logic signed [spsu_pkg::CMD_W-1:0]       strafe_x,
	input  wire logic signed [spsu_pkg::CMD_W-1:0]       forward_y,
	input  wire logic signed [spsu_pkg::CMD_W-1:0]       turn_rate,
	input  wire logic signed [COUNT_WIDTH-1:0]           count_front_right,
	input  wire logic signed [COUNT_WIDTH-1:0]           count_front_left,
	input  wire logic signed [COUNT_WIDTH-1:0]           count_back_right,
	input  wire logic signed [COUNT_WIDTH-1:0]           count_back_left,
	// output channel
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output logic signed [spsu_pkg::PIV_W-1:0]            pivot_front_right,
	output logic signed [spsu_pkg::PIV_W-1:0]            pivot_front_left,
	output logic signed [spsu_pkg::PIV_W-1:0]            pivot_back_right,
	output logic signed [spsu_pkg::PIV_W-1:0]            pivot_back_left,
	output logic [spsu_pkg::SPD_W-1:0]                   speed_front_right,
	output logic [spsu_pkg::SPD_W-1:0]                   speed_front_left,
	output logic [spsu_pkg::SPD_W-1:0]                   speed_back_right,
	output logic [spsu_pkg::SPD_W-1:0]                   speed_back_left
);

	// configuration registers
	logic [spsu_pkg::LEN_W-1:0]          len_q, wid_q;
	logic signed [spsu_pkg::GAIN_W-1:0]  kp_q, kd_q;
	logic [spsu_pkg::CPT_W-1:0]          cpt_q;
	// chassis ratios must be recomputed before the next word
	logic                                k_dirty_q;

	logic                                out_valid_q;
	spsu_pkg::spsu_cmd_t                 cmd;
	spsu_pkg::spsu_sts_t                 sts;
	logic [3:0][spsu_pkg::PIV_W-1:0]     pivot_res;
	logic [3:0][spsu_pkg::SPD_W-1:0]     speed_res;

	// writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= spsu_pkg::LENGTH_RST;
			wid_q     <= spsu_pkg::WIDTH_RST;
			kp_q      <= '0;
			kd_q      <= '0;
			cpt_q     <= spsu_pkg::CPT_RST;
			k_dirty_q <= 1'b1;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					spsu_pkg::REG_LENGTH: begin
						len_q     <= cfg_data[spsu_pkg::LEN_W-1:0];
						k_dirty_q <= 1'b1;
					end
					spsu_pkg::REG_WIDTH: begin
						wid_q     <= cfg_data[spsu_pkg::LEN_W-1:0];
						k_dirty_q <= 1'b1;
					end
					spsu_pkg::REG_PROP:  kp_q  <= $signed(cfg_data);
					spsu_pkg::REG_DERIV: kd_q  <= $signed(cfg_data);
					spsu_pkg::REG_CPT:   cpt_q <= cfg_data[spsu_pkg::CPT_W-1:0];
					default: ;
				endcase
			end
			// width ratio is the second one stored
			if (cmd.k_store && cmd.idx[0]) begin
				k_dirty_q <= 1'b0;
			end
		end
	end

	spsu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.k_dirty (k_dirty_q),
		.out_hold(out_valid_q && !out_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	spsu_dpath #(
		.COUNT_WIDTH      (COUNT_WIDTH),
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.len              (len_q),
		.wid              (wid_q),
		.kp               (kp_q),
		.kd               (kd_q),
		.cpt              (cpt_q),
		.strafe_x         (strafe_x),
		.forward_y        (forward_y),
		.turn_rate        (turn_rate),
		.count_front_right(count_front_right),
		.count_front_left (count_front_left),
		.count_back_right (count_back_right),
		.count_back_left  (count_back_left),
		.pivot_res        (pivot_res),
		.speed_res        (speed_res)
	);

	// output register, loaded when the controller publishes a finished word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			pivot_front_right <= pivot_res[0];
			pivot_front_left  <= pivot_res[1];
			pivot_back_right  <= pivot_res[2];
			pivot_back_left   <= pivot_res[3];
			speed_front_right <= speed_res[0];
			speed_front_left  <= speed_res[1];
			speed_back_right  <= speed_res[2];
			speed_back_left   <= speed_res[3];
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
